// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("%m: invariant violated");

// When the condition holds, the consequence holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, cond, conseq) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== hw/rtl/porq_pkg.sv =====
`default_nettype none
package porq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W = 8;
  localparam int PRI_W = 8;
  localparam int QCOUNT_W = 5;
  localparam int REQ_W = 2;
  localparam int STATUS_W = 2;
  localparam int IN_DATA_W = 16;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_INSERT = 2'd2
  } req_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } ctrl_state_t;

  typedef struct packed {
    logic load;   // capture the accepted request
    logic scan;   // register the per-cell compare mask
    logic apply;  // update the cells and load the result register
  } dp_cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/porq_ctrl.sv =====
`default_nettype none
module porq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output porq_pkg::dp_cmd_t     cmd
);
  import porq_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic out_valid;
  logic out_free;

  assign out_free = !out_valid || m_tready;
  assign m_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        // The result register must be free before the queue is touched.
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    cmd.load  = 1'b0;
    cmd.scan  = 1'b0;
    cmd.apply = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
      end
      S_APPLY: begin
        cmd.apply = out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.apply) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  `include "assert_macros.svh"

  `ASSERT_NEXT(a_scan_follows_load, clk, rst, cmd.load, state == S_SCAN)
  `ASSERT_NEXT(a_result_after_apply, clk, rst, cmd.apply, m_tvalid)
  `ASSERT_ALWAYS(a_no_overwrite, clk, rst, !(cmd.apply && out_valid && !m_tready))

endmodule
`default_nettype wire

// ===== hw/rtl/porq_dp.sv =====
`default_nettype none
module porq_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  porq_pkg::dp_cmd_t                      cmd,
  input  wire logic [porq_pkg::REQ_W-1:0]        in_req,
  input  wire logic [porq_pkg::ID_W-1:0]         in_id,
  input  wire logic [porq_pkg::PRI_W-1:0]        in_pri,
  output logic      [porq_pkg::STATUS_W-1:0]     res_status,
  output logic      [porq_pkg::ID_W-1:0]         res_id,
  output logic      [porq_pkg::PRI_W-1:0]        res_pri,
  output logic      [porq_pkg::QCOUNT_W-1:0]     res_count
);
  import porq_pkg::*;

  logic [REQ_W-1:0] req;
  logic [ID_W-1:0]  req_id;
  logic [PRI_W-1:0] req_pri;

  logic [ID_W-1:0]  ids  [QUEUE_DEPTH];
  logic [PRI_W-1:0] pris [QUEUE_DEPTH];
  logic [CNT_W-1:0] count;

  logic [QUEUE_DEPTH-1:0] hit;       // cell is at or after the insert point, unscanned
  logic [QUEUE_DEPTH-1:0] hit_q;
  logic [QUEUE_DEPTH-1:0] after;     // prefix OR of hit_q
  logic is_full;
  logic is_empty;
  logic do_place;
  logic do_pop;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req     <= in_req;
      req_id  <= in_id;
      req_pri <= in_pri;
    end
  end

  // A cell is a candidate when the new task outranks it, or when it is past the tail.
  // A push at the tail only uses the second rule.
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cmp
    always_comb begin
      if (CNT_W'(g) >= count) begin
        hit[g] = 1'b1;
      end else begin
        hit[g] = (req == REQ_INSERT) && (req_pri > pris[g]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      hit_q <= hit;
    end
  end

  always_comb begin
    after = hit_q;
    for (int s = 1; s < QUEUE_DEPTH; s = s * 2) begin
      after = after | (after << s);
    end
  end

  assign is_full  = (count == CNT_W'(QUEUE_DEPTH));
  assign is_empty = (count == '0);
  assign do_place = cmd.apply && !is_full && (req == REQ_PUSH || req == REQ_INSERT);
  assign do_pop   = cmd.apply && !is_empty && (req == REQ_POP);

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic first;
    logic [ID_W-1:0]  up_id;
    logic [PRI_W-1:0] up_pri;
    logic [ID_W-1:0]  dn_id;
    logic [PRI_W-1:0] dn_pri;

    if (g == 0) begin : g_head
      assign first  = after[g];
      assign up_id  = req_id;
      assign up_pri = req_pri;
    end else begin : g_body
      assign first  = after[g] && !after[g-1];
      assign up_id  = ids[g-1];
      assign up_pri = pris[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign dn_id  = ids[g];
      assign dn_pri = pris[g];
    end else begin : g_mid
      assign dn_id  = ids[g+1];
      assign dn_pri = pris[g+1];
    end

    always_ff @(posedge clk) begin
      if (do_place) begin
        if (first) begin
          ids[g]  <= req_id;
          pris[g] <= req_pri;
        end else if (after[g]) begin
          ids[g]  <= up_id;
          pris[g] <= up_pri;
        end
      end else if (do_pop) begin
        ids[g]  <= dn_id;
        pris[g] <= dn_pri;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (do_place) begin
      count <= count + CNT_W'(1);
    end else if (do_pop) begin
      count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      res_status <= ST_OK;
      res_id     <= '0;
      res_pri    <= '0;
      res_count  <= QCOUNT_W'(count);
      case (req)
        REQ_PUSH, REQ_INSERT: begin
          if (is_full) begin
            res_status <= ST_FULL;
          end else begin
            res_count <= QCOUNT_W'(count + CNT_W'(1));
          end
        end
        REQ_POP: begin
          if (is_empty) begin
            res_status <= ST_EMPTY;
          end else begin
            res_id    <= ids[0];
            res_pri   <= pris[0];
            res_count <= QCOUNT_W'(count - CNT_W'(1));
          end
        end
        default: begin
          res_status <= ST_OK;
        end
      endcase
    end
  end

  `include "assert_macros.svh"

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CNT_W'(QUEUE_DEPTH))
  `ASSERT_NEXT(a_count_held, clk, rst, !cmd.apply, $stable(count))
  `ASSERT_NEXT(a_count_step, clk, rst, cmd.apply,
    (count == $past(count)) || (count == $past(count) + CNT_W'(1)) ||
    (count + CNT_W'(1) == $past(count)))

endmodule
`default_nettype wire

// ===== hw/rtl/priority_ordered_ready_queue.sv =====
// Priority-ordered ready queue of up to QUEUE_DEPTH tasks (16). Each request on the
// slave stream is a push at the tail, a pop of the head, or an insert before the first
// entry of strictly lower priority; each gives exactly one result transfer on the master
// stream. After its transfer a request is handled in order: first, every cell
// compares its priority with the new one in parallel and the mask is registered;
// next, all cells shift at once and the result register is loaded; last, the result
// is offered. The next request is taken in the same cycle in which the result is
// offered, and none is taken while one is being compared or shifted; a result that
// is not taken holds the shift step of the following request until the result
// register frees up.
`default_nettype none
module priority_ordered_ready_queue (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // [7:0] task_id, [15:8] priority_req
  input  wire logic [porq_pkg::IN_DATA_W-1:0]      s_tdata,
  // [1:0] req_type
  input  wire logic [porq_pkg::REQ_W-1:0]          s_tuser,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // [7:0] popped_task_id, [15:8] popped_priority, [20:16] queue_count, [23:21] zero
  output logic      [porq_pkg::OUT_DATA_W-1:0]     m_tdata,
  // [1:0] status
  output logic      [porq_pkg::STATUS_W-1:0]       m_tuser
);
  import porq_pkg::*;

  dp_cmd_t cmd;
  logic [ID_W-1:0]     res_id;
  logic [PRI_W-1:0]    res_pri;
  logic [QCOUNT_W-1:0] res_count;

  porq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  porq_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_req     (s_tuser),
    .in_id      (s_tdata[ID_W-1:0]),
    .in_pri     (s_tdata[ID_W+PRI_W-1:ID_W]),
    .res_status (m_tuser),
    .res_id     (res_id),
    .res_pri    (res_pri),
    .res_count  (res_count)
  );

  assign m_tdata = {(OUT_DATA_W - ID_W - PRI_W - QCOUNT_W)'(0), res_count, res_pri, res_id};

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import porq_pkg::*;

  // Request code that the block leaves undefined; it must change nothing.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int RESET_CYCLES = 6;
  localparam int MAX_REPORTS = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    status_t               status;
    logic [ID_W-1:0]       task_id;
    logic [PRI_W-1:0]      pri;
    logic [QCOUNT_W-1:0]   count;
  } queue_result_t;

  class ready_queue_scoreboard;
    logic [ID_W-1:0]  held_ids[QUEUE_DEPTH];
    logic [PRI_W-1:0] held_pris[QUEUE_DEPTH];
    int               held;
    queue_result_t    awaited[$];
    int               failures;
    int               reported;

    function new();
      held = 0;
      failures = 0;
      reported = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void log_failure(string msg);
      failures++;
      if (reported < MAX_REPORTS) begin
        reported++;
        $display("%0t: %s", $time, msg);
      end
    endfunction

    // Applies one accepted request to the shadow queue and records its result.
    function void note_request(logic [REQ_W-1:0] req, logic [ID_W-1:0] id,
                               logic [PRI_W-1:0] pri);
      queue_result_t r;
      int slot;
      r.status = ST_OK;
      r.task_id = '0;
      r.pri = '0;
      if (req == REQ_PUSH || req == REQ_INSERT) begin
        if (held >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slot = held;
          if (req == REQ_INSERT) begin
            for (int i = 0; i < held; i++) begin
              if (pri > held_pris[i]) begin
                slot = i;
                break;
              end
            end
          end
          for (int i = held; i > slot; i--) begin
            held_ids[i] = held_ids[i-1];
            held_pris[i] = held_pris[i-1];
          end
          held_ids[slot] = id;
          held_pris[slot] = pri;
          held++;
        end
      end else if (req == REQ_POP) begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.task_id = held_ids[0];
          r.pri = held_pris[0];
          for (int i = 1; i < held; i++) begin
            held_ids[i-1] = held_ids[i];
            held_pris[i-1] = held_pris[i];
          end
          held--;
        end
      end
      r.count = QCOUNT_W'(held);
      awaited.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [ID_W-1:0] id,
                               logic [PRI_W-1:0] pri, logic [QCOUNT_W-1:0] count);
      queue_result_t e;
      if (awaited.size() == 0) begin
        log_failure($sformatf("unexpected result: status %0d id %0h pri %0h count %0d",
                              status, id, pri, count));
        return;
      end
      e = awaited.pop_front();
      if (status !== e.status || id !== e.task_id || pri !== e.pri || count !== e.count)
        log_failure($sformatf({"mismatch: expected status %0d id %0h pri %0h count %0d,",
                               " got status %0d id %0h pri %0h count %0d"},
                              e.status, e.task_id, e.pri, e.count, status, id, pri, count));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [REQ_W-1:0]      s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0]   m_tuser;

  ready_queue_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_ask = 0;

  priority_ordered_ready_queue i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off when one is asked for.
  always @(posedge clk) begin
    int hold_left;
    if (hold_ask != 0) begin
      hold_left = hold_ask;
      hold_ask = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Results are checked before the request of the same edge is noted; a request
  // never produces its own result on the edge that accepts it.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready)
        sb.check_result(m_tuser, m_tdata[7:0], m_tdata[15:8], m_tdata[20:16]);
      if (s_tvalid && s_tready)
        sb.note_request(s_tuser, s_tdata[7:0], s_tdata[15:8]);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_request(logic [REQ_W-1:0] req, logic [ID_W-1:0] id,
                              logic [PRI_W-1:0] pri);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct)
      gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= {pri, id};
    do @(posedge clk); while (!s_tready);
  endtask

  // Always waits on the clock before it returns, so valid is never lowered and raised in one step.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [REQ_W-1:0] pick_request(int fill_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < 3)
      return REQ_UNUSED;
    if ($urandom_range(99) < fill_pct)
      return ($urandom_range(99) < 60) ? REQ_INSERT : REQ_PUSH;
    return REQ_POP;
  endfunction

  // Clustered priorities make ties common so arrival order gets exercised.
  function automatic logic [PRI_W-1:0] pick_priority();
    case ($urandom_range(3))
      0: return PRI_W'($urandom_range(3));
      1: return PRI_W'(8'h80 + $urandom_range(1));
      2: return $urandom_range(1) ? 8'hFF : 8'h00;
      default: return PRI_W'($urandom_range(255));
    endcase
  endfunction

  task automatic run_random(int n_items);
    int done;
    int fill_pct;
    int run_len;
    logic [REQ_W-1:0] req;
    done = 0;
    while (done < n_items) begin
      case ($urandom_range(2))
        0: fill_pct = 85;
        1: fill_pct = 15;
        default: fill_pct = 50;
      endcase
      run_len = $urandom_range(4, 24);
      repeat (run_len) begin
        req = pick_request(fill_pct);
        send_request(req, ID_W'($urandom_range(255)), pick_priority());
        if (req != REQ_UNUSED)
          done++;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty pop, unused code, ordering with ties, push ignoring priority.
    send_request(REQ_POP, 8'h00, 8'h00);
    send_request(REQ_UNUSED, 8'hFF, 8'hFF);
    send_request(REQ_INSERT, 8'h01, 8'h80);
    send_request(REQ_INSERT, 8'h02, 8'h80);
    send_request(REQ_INSERT, 8'hFF, 8'hFF);
    send_request(REQ_INSERT, 8'h00, 8'h00);
    send_request(REQ_PUSH, 8'hA5, 8'hFF);
    send_request(REQ_INSERT, 8'h5A, 8'h00);
    send_request(REQ_INSERT, 8'h33, 8'h7F);
    send_request(REQ_UNUSED, 8'h00, 8'h00);
    repeat (8) send_request(REQ_POP, 8'hFF, 8'hFF);
    wait_drained();

    send_idle_pct = 21;
    recv_idle_pct = 68;
    run_random(230);

    // Hold the output long enough for the block to stall its input, while the
    // sender keeps offering enough adds to run the queue into full.
    wait_drained();
    hold_ask = HOLD_CYCLES;
    repeat (22)
      send_request(($urandom_range(1) ? REQ_INSERT : REQ_PUSH), ID_W'($urandom_range(255)),
                   pick_priority());
    wait_drained();

    send_idle_pct = 68;
    recv_idle_pct = 21;
    run_random(250);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(250);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.log_failure($sformatf("%0d results never arrived", sb.pending()));
    if (sb.failures == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
